[design/assert_macros.svh]
// Assertion macros shared by the bin averager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FMKMU_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("fmkmu check failed");
`define FMKMU_ASSERT_IMPL(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("fmkmu implication failed");
`else
`define FMKMU_ASSERT(label, prop)
`define FMKMU_ASSERT_IMPL(label, pre, post)
`endif
`endif

[design/fmkmu_pkg.sv]
// Shared types and constants of the (k, mu) bin averager.
package fmkmu_pkg;

   localparam int GRID_SIDE_DEF   = 64;
   localparam int MAX_K_BINS_DEF  = 64;
   localparam int MAX_MU_BINS_DEF = 16;

   localparam int CNT_W   = 18;
   localparam int KSUM_W  = 50;
   localparam int MUSUM_W = 34;
   localparam int PSUM_W  = 50;
   localparam int DIV_W   = 64;
   localparam int DEN_W   = 32;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_K_LOWEST      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_K_STEP        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_K_BIN_COUNT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MU_BIN_COUNT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_K_FUNDAMENTAL = 3'd4;

   typedef struct packed {
      logic [CNT_W-1:0]   count;
      logic [KSUM_W-1:0]  k_sum;
      logic [MUSUM_W-1:0] mu_sum;
      logic [PSUM_W-1:0]  power_sum;
   } bin_entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SQRT,
      ST_MUL,
      ST_KCHK,
      ST_KDIV,
      ST_MUDIV,
      ST_IMU,
      ST_ADDR,
      ST_ACC,
      ST_RD_LOAD,
      ST_RD_KDIV,
      ST_RD_MDIV,
      ST_RD_PDIV,
      ST_RD_OUT
   } state_type;

endpackage

[design/fft_mode_k_mu_bin_averager.sv]
// Top level: streaming (k, mu) binned averager of a half-complex power grid.
//
// Input channel req_*: one beat per grid cell (req_op = 0) or per bin read
// (req_op = 1). Cells arrive in storage order (x outer, y, z inner over
// 0..GRID_SIDE/2); internal counters track the position, req_last_mode
// restarts them. Each cell on the kept half-space and in the k range adds
// to one (k, mu) bin. A read beat returns one rsp_* beat with the bin's
// count and its average k, mu and power (zero when empty), then clears
// the bin. One item is worked at a time. A cell on the skipped half-plane
// is taken without leaving idle; a binned cell runs the bit-serial square
// root, then two passes of the shared 64-step restoring divider (k bin,
// then mu). Cells dropped on k range end early. A read of a filled bin runs
// three divider passes for the means. The bin state is one 152-bit wide
// memory with a registered read port, read-modify-written by the sequencer.
// Reset: after reset deasserts a clearing pass writes zero to all
// MAX_K_BINS * MAX_MU_BINS entries, one per cycle; req_ready stays low
// meanwhile. Config writes are taken at any time.
// Stall: the response sits in an output register; cell beats keep flowing
// while it waits, and a further read parks at its last step until it drains.
module fft_mode_k_mu_bin_averager #(
   parameter int GRID_SIDE   = fmkmu_pkg::GRID_SIDE_DEF,
   parameter int MAX_K_BINS  = fmkmu_pkg::MAX_K_BINS_DEF,
   parameter int MAX_MU_BINS = fmkmu_pkg::MAX_MU_BINS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic signed [31:0]                  req_mode_power,
   input  logic                                req_last_mode,
   input  logic [9:0]                          req_bin_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [17:0]                         rsp_mode_count,
   output logic [31:0]                         rsp_mean_k,
   output logic [16:0]                         rsp_mean_mu,
   output logic signed [31:0]                  rsp_mean_power,
   input  logic                                csr_we,
   input  logic [fmkmu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                         csr_wdata
);

`include "assert_macros.svh"

   localparam int PW        = $clog2(GRID_SIDE);
   localparam int HALF      = GRID_SIDE / 2;
   localparam int IKW       = 2 * PW + 2;
   localparam int RW        = PW + 17;
   localparam int RAD_W     = 2 * RW;
   localparam int SCW       = $clog2(RW);
   localparam int PRW       = 32 + RW;
   localparam int BIN_DEPTH = MAX_K_BINS * MAX_MU_BINS;
   localparam int BAW       = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
   localparam int KBW       = $clog2(MAX_K_BINS + 1);
   localparam int MBW       = $clog2(MAX_MU_BINS + 1);
   localparam int DCW       = $clog2(fmkmu_pkg::DIV_W);

   // ---------------- registers ----------------
   fmkmu_pkg::state_type state_ff, state_in;

   logic [31:0] k_lowest_ff, k_step_ff, k_fund_ff;
   logic [6:0]  k_bin_count_ff;
   logic [4:0]  mu_bin_count_ff;

   logic [PW-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [PW-1:0] pos_x_in, pos_y_in, pos_z_in;

   logic [BAW-1:0] clr_cnt_ff;

   // square root unit
   logic [RAD_W-1:0] rad_ff;
   logic [RW+1:0]    rem_ff;
   logic [RW-1:0]    root_ff;
   logic [SCW-1:0]   sq_cnt_ff;

   // shared divider
   logic [fmkmu_pkg::DIV_W-1:0] div_num_ff, div_quo_ff;
   logic [fmkmu_pkg::DEN_W-1:0] div_den_ff, div_rem_ff;
   logic [DCW-1:0]              div_cnt_ff;

   // per item work
   logic [PW-1:0]    kz_ff;
   logic [31:0]      power_ff;
   logic [PRW-1:0]   prod_ff;
   logic [31:0]      kq_ff;
   logic [KBW-1:0]   kbin_ff;
   logic [16:0]      mu_ff;
   logic [MBW-1:0]   imu_ff;
   logic [BAW-1:0]   bin_ff;
   logic             zero_ff;
   fmkmu_pkg::bin_entry_type ent_ff;
   logic [31:0]      res_k_ff;
   logic [16:0]      res_mu_ff;

   // response register
   logic        rsp_valid_ff;
   logic [17:0] rsp_count_ff;
   logic [31:0] rsp_k_ff, rsp_power_ff;
   logic [16:0] rsp_mu_ff;

   // bin memory
   fmkmu_pkg::bin_entry_type bin_mem [BIN_DEPTH];
   fmkmu_pkg::bin_entry_type mem_rdata_ff;

   // ---------------- combinational helpers ----------------
   logic accept;
   logic signed [PW:0] kx, ky, kz;
   logic signed [2*PW+1:0] sqx, sqy, sqz;
   logic [IKW-1:0] ik2;
   logic skip;
   logic idx_ok;
   logic [KBW-1:0] nk;
   logic [MBW-1:0] nmu;
   logic [31:0] kq;
   logic [RW+3:0] sq_rem2, sq_trial;
   logic sq_done;
   logic [fmkmu_pkg::DEN_W:0] div_rem2;
   logic div_take, div_run, div_done;
   logic [fmkmu_pkg::DIV_W-1:0] quo_next;
   logic [fmkmu_pkg::DEN_W-1:0] rem_next;
   logic [17+MBW-1:0] imu_prod;
   logic [MBW:0] imu_raw;
   logic [KBW+MBW-1:0] bin_calc;
   logic [fmkmu_pkg::PSUM_W-1:0] psum_mag;
   logic psum_neg;
   logic clr_done;

   logic mem_we, mem_re;
   logic [BAW-1:0] mem_waddr, mem_raddr;
   fmkmu_pkg::bin_entry_type mem_wdata, acc_entry;
   logic div_load;
   logic [fmkmu_pkg::DIV_W-1:0] div_num_ld;
   logic [fmkmu_pkg::DEN_W-1:0] div_den_ld;
   logic rsp_load;

   assign accept = req_valid && req_ready;

   // map storage index to signed wavenumber
   always_comb begin
      kx = ({1'b0, pos_x_ff} <= (PW+1)'(HALF)) ? $signed({1'b0, pos_x_ff})
         : $signed({1'b0, pos_x_ff} - (PW+1)'(GRID_SIDE));
      ky = ({1'b0, pos_y_ff} <= (PW+1)'(HALF)) ? $signed({1'b0, pos_y_ff})
         : $signed({1'b0, pos_y_ff} - (PW+1)'(GRID_SIDE));
      kz = $signed({1'b0, pos_z_ff});
      sqx = kx * kx;
      sqy = ky * ky;
      sqz = kz * kz;
      ik2 = IKW'($unsigned(sqx)) + IKW'($unsigned(sqy)) + IKW'($unsigned(sqz));
      // drop the redundant half of the z = 0 plane
      skip = (pos_z_ff == '0) && !((kx > 0) || ((kx == 0) && (ky > 0)));
   end

   // advance the position counters
   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      if (req_last_mode) begin
         pos_x_in = '0;
         pos_y_in = '0;
         pos_z_in = '0;
      end else if (pos_z_ff == PW'(HALF)) begin
         pos_z_in = '0;
         if (pos_y_ff == PW'(GRID_SIDE - 1)) begin
            pos_y_in = '0;
            pos_x_in = (pos_x_ff == PW'(GRID_SIDE - 1)) ? '0 : pos_x_ff + 1'b1;
         end else begin
            pos_y_in = pos_y_ff + 1'b1;
         end
      end else begin
         pos_z_in = pos_z_ff + 1'b1;
      end
   end

   always_comb begin
      idx_ok = (32'(req_bin_index) < BIN_DEPTH);
      nk = (32'(k_bin_count_ff) < MAX_K_BINS) ? KBW'(k_bin_count_ff) : KBW'(MAX_K_BINS);
      nmu = (32'(mu_bin_count_ff) < MAX_MU_BINS) ? MBW'(mu_bin_count_ff)
          : MBW'(MAX_MU_BINS);
      if (nmu == '0) begin
         nmu = MBW'(1);
      end
      // saturate k to 32 bits
      kq = (prod_ff[PRW-1:48] != '0) ? 32'hFFFF_FFFF : prod_ff[47:16];
      clr_done = (32'(clr_cnt_ff) == BIN_DEPTH - 1);
   end

   // square root step: two radicand bits per cycle
   always_comb begin
      sq_rem2  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      sq_trial = {2'b00, root_ff, 2'b01};
      sq_done  = (state_ff == fmkmu_pkg::ST_SQRT) && (32'(sq_cnt_ff) == RW - 1);
   end

   // restoring divider step: one quotient bit per cycle
   always_comb begin
      div_run = (state_ff == fmkmu_pkg::ST_KDIV) || (state_ff == fmkmu_pkg::ST_MUDIV)
             || (state_ff == fmkmu_pkg::ST_RD_KDIV) || (state_ff == fmkmu_pkg::ST_RD_MDIV)
             || (state_ff == fmkmu_pkg::ST_RD_PDIV);
      div_rem2 = {div_rem_ff, div_num_ff[fmkmu_pkg::DIV_W-1]};
      div_take = (div_rem2 >= {1'b0, div_den_ff});
      rem_next = div_take ? fmkmu_pkg::DEN_W'(div_rem2 - {1'b0, div_den_ff})
               : div_rem2[fmkmu_pkg::DEN_W-1:0];
      quo_next = {div_quo_ff[fmkmu_pkg::DIV_W-2:0], div_take};
      div_done = div_run && (div_cnt_ff == '1);
   end

   always_comb begin
      imu_prod = mu_ff * nmu;
      imu_raw  = imu_prod[17+MBW-1:16];
      bin_calc = kbin_ff * nmu + (KBW+MBW)'(imu_ff);
      psum_neg = ent_ff.power_sum[fmkmu_pkg::PSUM_W-1];
      psum_mag = psum_neg ? (~ent_ff.power_sum + 1'b1) : ent_ff.power_sum;
   end

   always_comb begin
      acc_entry.count     = mem_rdata_ff.count + 1'b1;
      acc_entry.k_sum     = mem_rdata_ff.k_sum + fmkmu_pkg::KSUM_W'(kq_ff);
      acc_entry.mu_sum    = mem_rdata_ff.mu_sum + fmkmu_pkg::MUSUM_W'(mu_ff);
      acc_entry.power_sum = mem_rdata_ff.power_sum
                          + {{(fmkmu_pkg::PSUM_W-32){power_ff[31]}}, power_ff};
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fmkmu_pkg::ST_CLEAR: begin
            if (clr_done) state_in = fmkmu_pkg::ST_IDLE;
         end
         fmkmu_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_op) begin
                  state_in = idx_ok ? fmkmu_pkg::ST_RD_LOAD : fmkmu_pkg::ST_RD_OUT;
               end else if (!skip) begin
                  state_in = fmkmu_pkg::ST_SQRT;
               end
            end
         end
         fmkmu_pkg::ST_SQRT: begin
            if (sq_done) state_in = fmkmu_pkg::ST_MUL;
         end
         fmkmu_pkg::ST_MUL:  state_in = fmkmu_pkg::ST_KCHK;
         fmkmu_pkg::ST_KCHK: begin
            state_in = (kq < k_lowest_ff) ? fmkmu_pkg::ST_IDLE : fmkmu_pkg::ST_KDIV;
         end
         fmkmu_pkg::ST_KDIV: begin
            if (div_done) begin
               state_in = (quo_next >= fmkmu_pkg::DIV_W'(nk)) ? fmkmu_pkg::ST_IDLE
                        : fmkmu_pkg::ST_MUDIV;
            end
         end
         fmkmu_pkg::ST_MUDIV: begin
            if (div_done) state_in = fmkmu_pkg::ST_IMU;
         end
         fmkmu_pkg::ST_IMU:  state_in = fmkmu_pkg::ST_ADDR;
         fmkmu_pkg::ST_ADDR: state_in = fmkmu_pkg::ST_ACC;
         fmkmu_pkg::ST_ACC:  state_in = fmkmu_pkg::ST_IDLE;
         fmkmu_pkg::ST_RD_LOAD: begin
            state_in = (mem_rdata_ff.count == '0) ? fmkmu_pkg::ST_RD_OUT
                     : fmkmu_pkg::ST_RD_KDIV;
         end
         fmkmu_pkg::ST_RD_KDIV: begin
            if (div_done) state_in = fmkmu_pkg::ST_RD_MDIV;
         end
         fmkmu_pkg::ST_RD_MDIV: begin
            if (div_done) state_in = fmkmu_pkg::ST_RD_PDIV;
         end
         fmkmu_pkg::ST_RD_PDIV: begin
            if (div_done) state_in = fmkmu_pkg::ST_RD_OUT;
         end
         fmkmu_pkg::ST_RD_OUT: begin
            if (!rsp_valid_ff || rsp_ready) state_in = fmkmu_pkg::ST_IDLE;
         end
         default: state_in = fmkmu_pkg::ST_IDLE;
      endcase
   end

   // ---------------- control outputs ----------------
   always_comb begin
      req_ready  = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = bin_ff;
      mem_wdata  = '0;
      mem_re     = 1'b0;
      mem_raddr  = bin_ff;
      div_load   = 1'b0;
      div_num_ld = '0;
      div_den_ld = '0;
      rsp_load   = 1'b0;
      case (state_ff)
         fmkmu_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
         end
         fmkmu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            mem_re    = req_valid && req_op && idx_ok;
            mem_raddr = BAW'(req_bin_index);
         end
         fmkmu_pkg::ST_KCHK: begin
            div_load   = (kq >= k_lowest_ff);
            div_num_ld = fmkmu_pkg::DIV_W'(kq - k_lowest_ff);
            div_den_ld = (k_step_ff == '0) ? 32'd1 : k_step_ff;
         end
         fmkmu_pkg::ST_KDIV: begin
            // mu = kz * 2^32 / r
            div_load   = div_done;
            div_num_ld = fmkmu_pkg::DIV_W'(kz_ff) << 32;
            div_den_ld = fmkmu_pkg::DEN_W'(root_ff);
         end
         fmkmu_pkg::ST_ADDR: begin
            mem_re    = 1'b1;
            mem_raddr = BAW'(bin_calc);
         end
         fmkmu_pkg::ST_ACC: begin
            mem_we    = 1'b1;
            mem_wdata = acc_entry;
         end
         fmkmu_pkg::ST_RD_LOAD: begin
            // clear the bin as it is read
            mem_we     = 1'b1;
            div_load   = (mem_rdata_ff.count != '0);
            div_num_ld = fmkmu_pkg::DIV_W'(mem_rdata_ff.k_sum);
            div_den_ld = fmkmu_pkg::DEN_W'(mem_rdata_ff.count);
         end
         fmkmu_pkg::ST_RD_KDIV: begin
            div_load   = div_done;
            div_num_ld = fmkmu_pkg::DIV_W'(ent_ff.mu_sum);
            div_den_ld = fmkmu_pkg::DEN_W'(ent_ff.count);
         end
         fmkmu_pkg::ST_RD_MDIV: begin
            div_load   = div_done;
            div_num_ld = fmkmu_pkg::DIV_W'(psum_mag);
            div_den_ld = fmkmu_pkg::DEN_W'(ent_ff.count);
         end
         fmkmu_pkg::ST_RD_OUT: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= fmkmu_pkg::ST_CLEAR;
         clr_cnt_ff      <= '0;
         pos_x_ff        <= '0;
         pos_y_ff        <= '0;
         pos_z_ff        <= '0;
         sq_cnt_ff       <= '0;
         div_cnt_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         k_lowest_ff     <= 32'd0;
         k_step_ff       <= 32'd65536;
         k_bin_count_ff  <= 7'd64;
         mu_bin_count_ff <= 5'd16;
         k_fund_ff       <= 32'd65536;
      end else begin
         state_ff <= state_in;
         if (state_ff == fmkmu_pkg::ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (accept && !req_op) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
            pos_z_ff <= pos_z_in;
         end
         if (accept && !req_op) begin
            sq_cnt_ff <= '0;
         end else if (state_ff == fmkmu_pkg::ST_SQRT) begin
            sq_cnt_ff <= sq_done ? '0 : sq_cnt_ff + 1'b1;
         end
         if (div_load) begin
            div_cnt_ff <= '0;
         end else if (div_run) begin
            div_cnt_ff <= div_cnt_ff + 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               fmkmu_pkg::REG_K_LOWEST:      k_lowest_ff     <= csr_wdata;
               fmkmu_pkg::REG_K_STEP:        k_step_ff       <= csr_wdata;
               fmkmu_pkg::REG_K_BIN_COUNT:   k_bin_count_ff  <= csr_wdata[6:0];
               fmkmu_pkg::REG_MU_BIN_COUNT:  mu_bin_count_ff <= csr_wdata[4:0];
               fmkmu_pkg::REG_K_FUNDAMENTAL: k_fund_ff       <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      case (state_ff)
         fmkmu_pkg::ST_IDLE: begin
            if (accept && !req_op) begin
               kz_ff    <= pos_z_ff;
               power_ff <= req_mode_power;
               rad_ff   <= RAD_W'(ik2) << 32;
               rem_ff   <= '0;
               root_ff  <= '0;
            end
            if (accept && req_op) begin
               zero_ff <= !idx_ok;
               bin_ff  <= BAW'(req_bin_index);
            end
         end
         fmkmu_pkg::ST_SQRT: begin
            rad_ff <= rad_ff << 2;
            if (sq_rem2 >= sq_trial) begin
               rem_ff  <= (RW+2)'(sq_rem2 - sq_trial);
               root_ff <= {root_ff[RW-2:0], 1'b1};
            end else begin
               rem_ff  <= sq_rem2[RW+1:0];
               root_ff <= {root_ff[RW-2:0], 1'b0};
            end
         end
         fmkmu_pkg::ST_MUL:  prod_ff <= k_fund_ff * root_ff;
         fmkmu_pkg::ST_KCHK: kq_ff   <= kq;
         fmkmu_pkg::ST_KDIV: begin
            if (div_done) kbin_ff <= quo_next[KBW-1:0];
         end
         fmkmu_pkg::ST_MUDIV: begin
            if (div_done) begin
               mu_ff <= (quo_next > 64'd65536) ? 17'd65536 : quo_next[16:0];
            end
         end
         fmkmu_pkg::ST_IMU: begin
            // top value of mu falls into the last bin
            imu_ff <= (imu_raw >= {1'b0, nmu}) ? nmu - 1'b1 : imu_raw[MBW-1:0];
         end
         fmkmu_pkg::ST_ADDR: bin_ff <= BAW'(bin_calc);
         fmkmu_pkg::ST_RD_LOAD: begin
            ent_ff  <= mem_rdata_ff;
            zero_ff <= (mem_rdata_ff.count == '0);
         end
         fmkmu_pkg::ST_RD_KDIV: begin
            if (div_done) res_k_ff <= quo_next[31:0];
         end
         fmkmu_pkg::ST_RD_MDIV: begin
            if (div_done) res_mu_ff <= quo_next[16:0];
         end
         default: begin
         end
      endcase

      if (div_load) begin
         div_num_ff <= div_num_ld;
         div_den_ff <= div_den_ld;
         div_rem_ff <= '0;
         div_quo_ff <= '0;
      end else if (div_run) begin
         div_num_ff <= div_num_ff << 1;
         div_rem_ff <= rem_next;
         div_quo_ff <= quo_next;
      end

      if (rsp_load) begin
         rsp_count_ff <= zero_ff ? '0 : ent_ff.count;
         rsp_k_ff     <= zero_ff ? '0 : res_k_ff;
         rsp_mu_ff    <= zero_ff ? '0 : res_mu_ff;
         // power mean truncates toward zero
         rsp_power_ff <= zero_ff ? '0
                       : (psum_neg ? (~div_quo_ff[31:0] + 1'b1) : div_quo_ff[31:0]);
      end
   end

   // ---------------- bin memory ----------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= bin_mem[mem_raddr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mode_count = rsp_count_ff;
   assign rsp_mean_k     = rsp_k_ff;
   assign rsp_mean_mu    = rsp_mu_ff;
   assign rsp_mean_power = $signed(rsp_power_ff);

   // ---------------- checks ----------------
   `FMKMU_ASSERT_IMPL(a_no_write_idle, mem_we, state_ff != fmkmu_pkg::ST_IDLE)
   `FMKMU_ASSERT_IMPL(a_div_cnt_rest, !div_run, div_cnt_ff == '0)
   `FMKMU_ASSERT_IMPL(a_rsp_from_read, $rose(rsp_valid_ff), $past(state_ff) == fmkmu_pkg::ST_RD_OUT)
   `FMKMU_ASSERT_IMPL(a_acc_in_range, state_ff == fmkmu_pkg::ST_ACC, 32'(bin_ff) < BIN_DEPTH)

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the streaming (k, mu) bin averager.
module tb_top;

   localparam int  SIDE       = 64;
   localparam int  HALF       = SIDE / 2;
   localparam int  N_BINS     = 1024;
   localparam int  TAIL_WAIT  = 260;        // longer than one binned cell or one read
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic [17:0]        cnt;
      logic [31:0]        mean_k;
      logic [16:0]        mean_mu;
      logic signed [31:0] mean_pw;
   } bin_mean_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_op = 1'b0;
   logic signed [31:0] req_mode_power = '0;
   logic               req_last_mode = 1'b0;
   logic [9:0]         req_bin_index = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [17:0]        rsp_mode_count;
   logic [31:0]        rsp_mean_k;
   logic [16:0]        rsp_mean_mu;
   logic signed [31:0] rsp_mean_power;
   logic               csr_we = 1'b0;
   logic [fmkmu_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   // shadow configuration
   logic [31:0] k_low_q, k_step_q, k_fund_q;
   logic [6:0]  n_kbin_q;
   logic [4:0]  n_mubin_q;

   // shadow grid position and bin store
   logic [5:0]  grid_x, grid_y, grid_z;
   logic [17:0] sh_cnt   [N_BINS];
   logic [49:0] sh_ksum  [N_BINS];
   logic [33:0] sh_musum [N_BINS];
   logic [49:0] sh_pwsum [N_BINS];

   bin_mean_type mean_q[$];
   int          fail_count = 0;
   longint      cycle_count = 0;
   int          rsp_hold_cycles = 0;
   bit          rsp_no_idle = 1'b0;
   bit          req_no_idle = 1'b0;

   always #4 clock = ~clock;

   fft_mode_k_mu_bin_averager DUT (.*);

   // ---------------------------------------------------------------- model

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, one;
      root = 0;
      one  = 64'd1 << 62;
      while (one > v) one >>= 2;
      while (one != 0) begin
         if (v >= root + one) begin
            v    -= root + one;
            root  = (root >> 1) + one;
         end else begin
            root >>= 1;
         end
         one >>= 2;
      end
      return root;
   endfunction

   function automatic int wave_number(logic [5:0] i);
      return (i <= HALF) ? int'(i) : int'(i) - SIDE;
   endfunction

   // Add one grid cell at the current position to its (k, mu) bin.
   function automatic void bin_cell(logic [31:0] pw);
      int kx, ky, kz;
      longint unsigned k2, root, kw, mu, nk, nmu, kbin, imu, slot, stepv;
      logic [31:0] kq;
      kx = wave_number(grid_x);
      ky = wave_number(grid_y);
      kz = int'(grid_z);
      // drop the redundant half-plane, the zero mode included
      if (kz == 0 && !(kx > 0 || (kx == 0 && ky > 0))) return;
      k2   = longint'(kx * kx + ky * ky + kz * kz);
      root = int_sqrt(k2 << 32);
      if (root == 0) return;
      kw = (longint'(k_fund_q) * root) >> 16;
      kq = (kw > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : kw[31:0];
      if (kq < k_low_q) return;
      stepv = (k_step_q == 0) ? 1 : longint'(k_step_q);
      kbin  = longint'(kq - k_low_q) / stepv;
      nk    = (n_kbin_q < 64) ? n_kbin_q : 64;
      if (kbin >= nk) return;
      nmu = (n_mubin_q < 16) ? n_mubin_q : 16;
      if (nmu == 0) nmu = 1;
      mu = (longint'(kz) << 32) / root;
      if (mu > 65536) mu = 65536;
      imu = (mu * nmu) >> 16;
      if (imu >= nmu) imu = nmu - 1;   // mu = 1 lands in the top bin
      slot = kbin * nmu + imu;
      if (slot >= N_BINS) return;
      sh_cnt[slot]   = sh_cnt[slot] + 18'd1;
      sh_ksum[slot]  = sh_ksum[slot] + 50'(kq);
      sh_musum[slot] = sh_musum[slot] + 34'(mu);
      sh_pwsum[slot] = sh_pwsum[slot] + {{18{pw[31]}}, pw};
   endfunction

   function automatic void step_position(bit last);
      if (last) begin
         grid_x = 0; grid_y = 0; grid_z = 0;
         return;
      end
      if (grid_z == HALF) begin
         grid_z = 0;
         if (grid_y == SIDE - 1) begin
            grid_y = 0;
            grid_x = grid_x + 6'd1;
         end else begin
            grid_y = grid_y + 6'd1;
         end
      end else begin
         grid_z = grid_z + 6'd1;
      end
   endfunction

   // Read one bin's averages, clear the bin, and queue the expected beat.
   function automatic void read_bin(logic [9:0] idx);
      bin_mean_type m;
      longint n, sp;
      m = '0;
      n = longint'(sh_cnt[idx]);
      if (n != 0) begin
         sp        = longint'(signed'({{14{sh_pwsum[idx][49]}}, sh_pwsum[idx]}));
         m.cnt     = sh_cnt[idx];
         m.mean_k  = 32'(longint'(sh_ksum[idx]) / n);
         m.mean_mu = 17'(longint'(sh_musum[idx]) / n);
         m.mean_pw = 32'(sp / n);
      end
      sh_cnt[idx] = 0; sh_ksum[idx] = 0; sh_musum[idx] = 0; sh_pwsum[idx] = 0;
      mean_q.push_back(m);
   endfunction

   // ---------------------------------------------------------------- drivers

   // Offer one beat after a random gap and return at the edge that takes it.
   task automatic send_item(bit op, logic [31:0] pw, bit last, logic [9:0] idx);
      int gap;
      gap = req_no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_mode_power <= pw;
      req_last_mode  <= last;
      req_bin_index  <= idx;
      do @(posedge clock); while (!req_ready);
      if (op) begin
         read_bin(idx);
      end else begin
         bin_cell(pw);
         step_position(last);
      end
   endtask

   task automatic send_cell(logic [31:0] pw, bit last);
      send_item(1'b0, pw, last, 10'($urandom_range(0, 1023)));
   endtask

   task automatic send_read(logic [9:0] idx);
      send_item(1'b1, $urandom, 1'($urandom_range(0, 1)), idx);
   endtask

   // Hold the input until every expected beat is back and the block is idle.
   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mean_q.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(logic [fmkmu_pkg::CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         fmkmu_pkg::REG_K_LOWEST:      k_low_q   = data;
         fmkmu_pkg::REG_K_STEP:        k_step_q  = data;
         fmkmu_pkg::REG_K_BIN_COUNT:   n_kbin_q  = data[6:0];
         fmkmu_pkg::REG_MU_BIN_COUNT:  n_mubin_q = data[4:0];
         fmkmu_pkg::REG_K_FUNDAMENTAL: k_fund_q  = data;
         default: ;
      endcase
   endtask

   task automatic set_binning(logic [31:0] low, logic [31:0] stp, logic [6:0] nk,
                              logic [4:0] nmu, logic [31:0] kf);
      drain_block();
      csr_write(fmkmu_pkg::REG_K_LOWEST, low);
      csr_write(fmkmu_pkg::REG_K_STEP, stp);
      csr_write(fmkmu_pkg::REG_K_BIN_COUNT, 32'(nk));
      csr_write(fmkmu_pkg::REG_MU_BIN_COUNT, 32'(nmu));
      csr_write(fmkmu_pkg::REG_K_FUNDAMENTAL, kf);
   endtask

   function automatic logic [31:0] pick_power();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   // Bins that the current setting can fill, so most reads hit live data.
   function automatic int live_bins();
      int nk, nmu;
      nk  = (n_kbin_q < 64) ? n_kbin_q : 64;
      nmu = (n_mubin_q < 16) ? n_mubin_q : 16;
      if (nmu == 0) nmu = 1;
      return (nk == 0) ? 1 : nk * nmu;
   endfunction

   // Short partial grid passes with random content, with reads mixed in.
   task automatic run_traffic(int n_items);
      int sent, len, i, span;
      sent = 0;
      while (sent < n_items) begin
         len = $urandom_range(1, 70);
         for (i = 0; i < len && sent < n_items; i++) begin
            span = live_bins();
            if ($urandom_range(0, 4) == 0) begin
               if ($urandom_range(0, 5) == 0) send_read(10'($urandom_range(0, 1023)));
               else send_read(10'($urandom_range(0, span - 1)));
            end else begin
               send_cell(pick_power(), (i == len - 1) ? ($urandom_range(0, 3) != 0) : 1'b0);
            end
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------- tests

   // Zero mode, mu = 1 clamp, power extremes, reads that ignore last_mode.
   task automatic test_directed();
      int i;
      send_cell(32'h7FFF_FFFF, 1'b0);        // zero mode: skipped
      send_cell(32'h8000_0000, 1'b0);        // kz only: mu = 1
      send_cell(32'h7FFF_FFFF, 1'b0);
      send_read(10'd31);                     // k bin 1, top mu bin
      send_item(1'b1, 32'h0, 1'b1, 10'd47);  // read with last_mode set
      send_cell(32'hFFFF_FFFF, 1'b0);
      send_cell(32'h0000_0001, 1'b1);        // restart the position
      send_cell(32'h1234_5678, 1'b0);
      send_cell(32'h0001_0000, 1'b0);
      send_read(10'd1023);                   // empty, the last bin of the live range
      for (i = 0; i < 64; i++) send_read(10'(i));
   endtask

   // Bin counts and step at their extremes.
   task automatic test_config_corners();
      int i;
      set_binning(32'h0, 32'h0, 7'd127, 5'd0, 32'h0000_4000);   // zero step, nmu 0
      for (i = 0; i < 20; i++) send_cell(pick_power(), i == 19);
      for (i = 0; i < 12; i++) send_read(10'(i));
      set_binning(32'h0, 32'h1_0000, 7'd0, 5'd31, 32'h1_0000); // no k bins
      for (i = 0; i < 10; i++) send_cell(pick_power(), i == 9);
      send_read(10'd0);
      set_binning(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd1, 5'd16, 32'hFFFF_FFFF); // saturated k
      for (i = 0; i < 12; i++) send_cell(pick_power(), i == 11);
      for (i = 0; i < 16; i++) send_read(10'(i));
      set_binning(32'h0, 32'h1, 7'd64, 5'd1, 32'h1);            // smallest step and fundamental
      for (i = 0; i < 12; i++) send_cell(pick_power(), i == 11);
      for (i = 0; i < 64; i++) send_read(10'(i));
   endtask

   // Walk several y rows past the z wrap; cells beyond the two k bins drop early.
   task automatic test_grid_walk();
      int i;
      set_binning(32'h0, 32'h4_0000, 7'd2, 5'd2, 32'h1_0000);
      for (i = 0; i < 100; i++) send_cell(pick_power(), 1'b0);
      for (i = 0; i < 4; i++) send_read(10'(i));
   endtask

   // Park the receiver so reads back up, then pause the sender until empty.
   task automatic test_backpressure();
      int i;
      drain_block();
      rsp_hold_cycles = 3000;
      @(posedge clock);
      req_no_idle = 1'b1;
      for (i = 0; i < 12; i++) send_read(10'($urandom_range(0, live_bins() - 1)));
      for (i = 0; i < 8; i++) send_cell(pick_power(), 1'b0);
      req_no_idle = 1'b0;
      drain_block();
   endtask

   task automatic test_random();
      set_binning(32'h0, 32'h1_0000, 7'd64, 5'd16, 32'h1_0000);
      run_traffic(100);
      set_binning(32'h1_0000, 32'h4000, 7'd8, 5'd4, 32'h1_0000);
      rsp_no_idle = 1'b1;
      run_traffic(80);
      rsp_no_idle = 1'b0;
      set_binning($urandom_range(0, 32'h8_0000), $urandom_range(1, 32'h8_0000),
                  7'($urandom_range(1, 64)), 5'($urandom_range(1, 16)),
                  $urandom_range(1, 32'h4_0000));
      run_traffic(100);
      set_binning(32'h0, 32'h2_0000, 7'd20, 5'd7, 32'h1_9220);
      req_no_idle = 1'b1;
      run_traffic(70);
      req_no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------- receiver

   // Stall a random number of cycles per beat; honor a long hold when asked.
   always begin
      int stall;
      if (rsp_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         repeat (rsp_hold_cycles) @(posedge clock);
         rsp_hold_cycles = 0;
      end else begin
         stall = rsp_no_idle ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
      rsp_ready <= 1'b1;
      do @(posedge clock); while (!(rsp_valid && rsp_ready) && rsp_hold_cycles == 0);
   end

   // Compare each beat with the oldest expected bin average.
   always @(posedge clock) begin
      bin_mean_type m;
      if (!reset && rsp_valid && rsp_ready) begin
         if (mean_q.size() == 0) begin
            $error("unexpected beat: count %0d", rsp_mode_count);
            fail_count++;
         end else begin
            m = mean_q.pop_front();
            if (rsp_mode_count !== m.cnt) begin
               $error("mode_count expected %0d actual %0d", m.cnt, rsp_mode_count);
               fail_count++;
            end
            if (rsp_mean_k !== m.mean_k) begin
               $error("mean_k expected %h actual %h", m.mean_k, rsp_mean_k);
               fail_count++;
            end
            if (rsp_mean_mu !== m.mean_mu) begin
               $error("mean_mu expected %h actual %h", m.mean_mu, rsp_mean_mu);
               fail_count++;
            end
            if (rsp_mean_power !== m.mean_pw) begin
               $error("mean_power expected %h actual %h", m.mean_pw, rsp_mean_power);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int i;
      k_low_q = 0; k_step_q = 32'h1_0000; n_kbin_q = 7'd64; n_mubin_q = 5'd16;
      k_fund_q = 32'h1_0000;
      grid_x = 0; grid_y = 0; grid_z = 0;
      for (i = 0; i < N_BINS; i++) begin
         sh_cnt[i] = 0; sh_ksum[i] = 0; sh_musum[i] = 0; sh_pwsum[i] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_corners();
      test_grid_walk();
      test_backpressure();
      test_random();
      drain_block();
      if (fail_count == 0 && mean_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
